@@ sv/ffha_pkg.sv @@
// Shared types and constants for the first-fit hole allocator.
// Holds the table depth, status codes and the command structs sent to the hole cells.
// Used by ffha_cell and first_fit_hole_allocator; depends on nothing.
package ffha_pkg;

	localparam int MAX_HOLES = 32;
	localparam int IDX_W = $clog2(MAX_HOLES);
	localparam int CNT_W = $clog2(MAX_HOLES + 1);

	localparam logic [15:0] POOL_BASE_RST = 16'h3000;
	localparam logic [15:0] POOL_SIZE_RST = 16'h7000;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	localparam logic REG_POOL_BASE = 1'b0;
	localparam logic REG_POOL_SIZE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_OOM = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic cap_en;
		logic func;
		logic [15:0] addr;
		logic [15:0] size;
		logic [CNT_W-1:0] count;
	} cell_cmp_t;

	typedef struct packed {
		logic wr_en;
		logic [IDX_W-1:0] wr_pos;
		logic [15:0] wr_start;
		logic [15:0] wr_len;
		logic drop_en;
		logic ins_en;
		logic [IDX_W-1:0] sh_pos;
	} cell_cmd_t;

endpackage

@@ sv/first_fit_hole_allocator.sv @@
// First-fit hole allocator: a row of hole cells in address order plus the control around it.
// Depends on ffha_pkg and ffha_cell.
//
// A request is accepted when start is high and busy is low, and its result beat appears on
// granted_addr, status and holes_in_use with done high for one cycle, after the compare, select
// and apply states; busy is low again in that cycle, and no new request is taken until then.
// The four steps are: accept, compare in every cell at once, pick the first matching cell and
// its neighbor, then update the row with one write, shift or both. Results cannot be held off.
// After reset the block is busy in its init state while the initial hole is loaded. A write to
// pool_base or pool_size reloads the table with that single hole and must be done while idle.
module first_fit_hole_allocator (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic func,
	input logic [15:0] block_addr,
	input logic [15:0] block_size,
	output logic done,
	output logic [15:0] granted_addr,
	output logic [1:0] status,
	output logic [5:0] holes_in_use,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int N = ffha_pkg::MAX_HOLES;
	localparam int IW = ffha_pkg::IDX_W;
	localparam int CW = ffha_pkg::CNT_W;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CMP,
		S_SEL,
		S_APPLY
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [15:0] pool_base_q;
	logic [15:0] pool_size_q;
	logic func_q;
	logic [15:0] addr_q;
	logic [15:0] size_q;
	logic done_q;
	logic [15:0] granted_q;
	ffha_pkg::status_t status_q;
	logic [5:0] holes_q;

	logic [15:0] cs [N];
	logic [15:0] cl [N];
	logic [N-1:0] hit;
	logic [N-1:0] valid;
	logic [N-1:0] firstsel;
	logic [N-1:0] prevsel;
	logic found;
	logic [IW-1:0] k_idx;
	logic [CW-1:0] m_idx;
	logic [15:0] cur_start;
	logic [15:0] cur_len;
	logic [15:0] prev_start;
	logic [15:0] prev_len;

	logic found_s2;
	logic [CW-1:0] m_s2;
	logic [15:0] cur_start_s2;
	logic [15:0] cur_len_s2;
	logic [15:0] prev_start_s2;
	logic [15:0] prev_len_s2;

	logic cfg_wr;
	logic [15:0] load_base;
	logic [15:0] load_size;
	ffha_pkg::cell_cmp_t cmp;
	ffha_pkg::cell_cmd_t cmd;
	ffha_pkg::cell_cmd_t apply_cmd;
	logic [15:0] granted_d;
	ffha_pkg::status_t status_d;
	logic [CW-1:0] count_d;

	logic [15:0] bend;
	logic [15:0] pend;
	logic [IW-1:0] q_pos;
	logic [IW-1:0] p_pos;
	logic full;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == ffha_pkg::REG_POOL_SIZE) ? {16'b0, pool_size_q}
		: {16'b0, pool_base_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= ffha_pkg::POOL_BASE_RST;
			pool_size_q <= ffha_pkg::POOL_SIZE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == ffha_pkg::REG_POOL_SIZE) begin
				pool_size_q <= pwdata[15:0];
			end else begin
				pool_base_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		load_base = pool_base_q;
		load_size = pool_size_q;
		if (cfg_wr && (paddr[2] == ffha_pkg::REG_POOL_BASE)) begin
			load_base = pwdata[15:0];
		end
		if (cfg_wr && (paddr[2] == ffha_pkg::REG_POOL_SIZE)) begin
			load_size = pwdata[15:0];
		end
	end

	assign cmp.cap_en = (state_q == S_CMP);
	assign cmp.func = func_q;
	assign cmp.addr = addr_q;
	assign cmp.size = size_q;
	assign cmp.count = count_q;

	for (genvar g = 0; g < N; g++) begin : g_cell
		localparam int L = (g == 0) ? 0 : g - 1;
		localparam int R = (g == N - 1) ? g : g + 1;

		ffha_cell u_cell (
			.clk(clk),
			.cell_idx(IW'(g)),
			.cmp(cmp),
			.cmd(cmd),
			.left_start(cs[L]),
			.left_len(cl[L]),
			.right_start(cs[R]),
			.right_len(cl[R]),
			.start(cs[g]),
			.len(cl[g]),
			.hit(hit[g])
		);

		assign valid[g] = CW'(g) < count_q;

		if (g == 0) begin : g_head
			assign firstsel[g] = hit[g];
		end else begin : g_body
			assign firstsel[g] = hit[g] & ~(|hit[g-1:0]);
		end

		if (g == N - 1) begin : g_tail
			assign prevsel[g] = ~found & valid[g];
		end else begin : g_mid
			assign prevsel[g] = firstsel[g+1] | (~found & valid[g] & ~valid[g+1]);
		end
	end

	assign found = |hit;

	always_comb begin
		k_idx = '0;
		cur_start = '0;
		cur_len = '0;
		prev_start = '0;
		prev_len = '0;
		for (int i = 0; i < N; i++) begin
			if (firstsel[i]) begin
				k_idx = k_idx | IW'(i);
				cur_start = cur_start | cs[i];
				cur_len = cur_len | cl[i];
			end
			if (prevsel[i]) begin
				prev_start = prev_start | cs[i];
				prev_len = prev_len | cl[i];
			end
		end
		m_idx = found ? CW'(k_idx) : count_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			func_q <= func;
			addr_q <= block_addr;
			size_q <= block_size;
		end
		if (state_q == S_SEL) begin
			found_s2 <= found;
			m_s2 <= m_idx;
			cur_start_s2 <= cur_start;
			cur_len_s2 <= cur_len;
			prev_start_s2 <= prev_start;
			prev_len_s2 <= prev_len;
		end
	end

	assign bend = addr_q + size_q;
	assign pend = prev_start_s2 + prev_len_s2;
	assign q_pos = m_s2[IW-1:0];
	assign p_pos = IW'(m_s2 - CW'(1));
	assign full = count_q >= CW'(N);

	always_comb begin
		apply_cmd = '0;
		granted_d = '0;
		status_d = ffha_pkg::ST_OK;
		count_d = count_q;
		if (func_q == ffha_pkg::FUNC_ALLOC) begin
			if (!found_s2) begin
				status_d = ffha_pkg::ST_OOM;
			end else if (cur_len_s2 == size_q) begin
				granted_d = cur_start_s2;
				apply_cmd.drop_en = 1'b1;
				apply_cmd.sh_pos = q_pos;
				count_d = count_q - CW'(1);
			end else begin
				granted_d = cur_start_s2 + cur_len_s2 - size_q;
				apply_cmd.wr_en = 1'b1;
				apply_cmd.wr_pos = q_pos;
				apply_cmd.wr_start = cur_start_s2;
				apply_cmd.wr_len = cur_len_s2 - size_q;
			end
		end else if (count_q == '0) begin
			apply_cmd.wr_en = 1'b1;
			apply_cmd.ins_en = 1'b1;
			apply_cmd.wr_pos = '0;
			apply_cmd.sh_pos = '0;
			apply_cmd.wr_start = addr_q;
			apply_cmd.wr_len = size_q;
			count_d = CW'(1);
		end else if (bend == cs[0]) begin
			apply_cmd.wr_en = 1'b1;
			apply_cmd.wr_pos = '0;
			apply_cmd.wr_start = addr_q;
			apply_cmd.wr_len = cl[0] + size_q;
		end else if (!found_s2 && pend == addr_q) begin
			apply_cmd.wr_en = 1'b1;
			apply_cmd.wr_pos = p_pos;
			apply_cmd.wr_start = prev_start_s2;
			apply_cmd.wr_len = prev_len_s2 + size_q;
		end else if (!found_s2 || m_s2 == '0 || (pend < addr_q && bend < cur_start_s2)) begin
			if (full) begin
				status_d = ffha_pkg::ST_FULL;
			end else begin
				apply_cmd.wr_en = 1'b1;
				apply_cmd.ins_en = 1'b1;
				apply_cmd.wr_pos = q_pos;
				apply_cmd.sh_pos = q_pos;
				apply_cmd.wr_start = addr_q;
				apply_cmd.wr_len = size_q;
				count_d = count_q + CW'(1);
			end
		end else if (pend == addr_q && bend < cur_start_s2) begin
			apply_cmd.wr_en = 1'b1;
			apply_cmd.wr_pos = p_pos;
			apply_cmd.wr_start = prev_start_s2;
			apply_cmd.wr_len = prev_len_s2 + size_q;
		end else if (pend < addr_q && bend == cur_start_s2) begin
			apply_cmd.wr_en = 1'b1;
			apply_cmd.wr_pos = q_pos;
			apply_cmd.wr_start = addr_q;
			apply_cmd.wr_len = cur_len_s2 + size_q;
		end else begin
			apply_cmd.wr_en = 1'b1;
			apply_cmd.wr_pos = p_pos;
			apply_cmd.wr_start = prev_start_s2;
			apply_cmd.wr_len = prev_len_s2 + size_q + cur_len_s2;
			apply_cmd.drop_en = 1'b1;
			apply_cmd.sh_pos = q_pos;
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		cmd = '0;
		if (cfg_wr || state_q == S_INIT) begin
			cmd.wr_en = 1'b1;
			cmd.wr_pos = '0;
			cmd.wr_start = load_base;
			cmd.wr_len = load_size;
		end else if (state_q == S_APPLY) begin
			cmd = apply_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			count_q <= CW'(1);
			done_q <= 1'b0;
			granted_q <= '0;
			status_q <= ffha_pkg::ST_OK;
			holes_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				count_q <= CW'(1);
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					count_q <= count_d;
					done_q <= 1'b1;
					granted_q <= granted_d;
					status_q <= status_d;
					holes_q <= 6'(count_d);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign granted_addr = granted_q;
	assign status = status_q;
	assign holes_in_use = holes_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(N))
		else $error("hole count above table depth");

	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_APPLY) |=> done)
		else $error("no result beat after update step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ffha_pkg::ST_FULL) |-> (holes_in_use == 6'(N)))
		else $error("table full reported with free entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ffha_pkg::ST_OOM) |-> (granted_addr == '0))
		else $error("address granted on out of memory");

endmodule

@@ sv/ffha_cell.sv @@
// One entry of the hole table: a start address, a length and a registered match flag.
// Shifts toward either neighbor on remove or insert and takes direct writes.
// Depends on ffha_pkg.
module ffha_cell (
	input logic clk,
	input logic [ffha_pkg::IDX_W-1:0] cell_idx,
	input ffha_pkg::cell_cmp_t cmp,
	input ffha_pkg::cell_cmd_t cmd,
	input logic [15:0] left_start,
	input logic [15:0] left_len,
	input logic [15:0] right_start,
	input logic [15:0] right_len,
	output logic [15:0] start,
	output logic [15:0] len,
	output logic hit
);

	logic [15:0] start_q;
	logic [15:0] len_q;
	logic hit_q;
	logic valid;
	logic hit_d;
	logic [15:0] start_d;
	logic [15:0] len_d;

	assign valid = ffha_pkg::CNT_W'(cell_idx) < cmp.count;

	always_comb begin
		if (cmp.func == ffha_pkg::FUNC_FREE) begin
			hit_d = valid && (start_q >= cmp.addr);
		end else begin
			hit_d = valid && (len_q >= cmp.size);
		end
	end

	always_comb begin
		start_d = start_q;
		len_d = len_q;
		if (cmd.wr_en && (cell_idx == cmd.wr_pos)) begin
			start_d = cmd.wr_start;
			len_d = cmd.wr_len;
		end else if (cmd.drop_en && (cell_idx >= cmd.sh_pos)) begin
			start_d = right_start;
			len_d = right_len;
		end else if (cmd.ins_en && (cell_idx > cmd.sh_pos)) begin
			start_d = left_start;
			len_d = left_len;
		end
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		len_q <= len_d;
		if (cmp.cap_en) begin
			hit_q <= hit_d;
		end
	end

	assign start = start_q;
	assign len = len_q;
	assign hit = hit_q;

endmodule
